FILE: design/cbr_pkg.sv
// Shared constants and types for the cursor bitmap rotator.
package cbr_pkg;

  localparam int SIDE      = 32;
  localparam int COORD_W   = $clog2(SIDE);
  localparam int LANES     = 8;
  localparam int LANE_W    = $clog2(LANES);
  localparam int BPR       = SIDE / LANES;
  localparam int BPR_W     = $clog2(BPR);
  localparam int PAIRS     = SIDE * BPR;
  localparam int CNT_W     = $clog2(PAIRS);
  localparam int IN_DATA_W = 16;
  localparam int OUT_RAW_W = COORD_W + 2 * SIDE;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic               and_b;
    logic               xor_b;
  } pix_t;

endpackage

FILE: design/cbr_lane.sv
// One pixel lane: mask logic and rotated target position.
module cbr_lane (
  input  logic [cbr_pkg::COORD_W-1:0] x_i,
  input  logic [cbr_pkg::COORD_W-1:0] y_i,
  input  cbr_pkg::rot_e               rot_i,
  input  logic                        img_i,
  input  logic                        msk_i,
  output cbr_pkg::pix_t               pix_o
);

  always_comb begin
    pix_o.and_b = ~msk_i;
    pix_o.xor_b = img_i & msk_i;
    case (rot_i)
      cbr_pkg::ROT_90: begin
        pix_o.nx = ~y_i;
        pix_o.ny = x_i;
      end
      cbr_pkg::ROT_180: begin
        pix_o.nx = ~x_i;
        pix_o.ny = ~y_i;
      end
      cbr_pkg::ROT_270: begin
        pix_o.nx = y_i;
        pix_o.ny = ~x_i;
      end
      default: begin
        pix_o.nx = x_i;
        pix_o.ny = y_i;
      end
    endcase
  end

endmodule

FILE: design/cbr_store.sv
// Merges the lane pixels into the AND/XOR bit stores and reads out one row.
module cbr_store (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic                              clr_i,
  input  cbr_pkg::pix_t [cbr_pkg::LANES-1:0] pix_i,
  input  logic [cbr_pkg::COORD_W-1:0]       rd_row_i,
  output logic [cbr_pkg::SIDE-1:0]          rd_and_o,
  output logic [cbr_pkg::SIDE-1:0]          rd_xor_o
);

  logic [cbr_pkg::SIDE-1:0] and_q [cbr_pkg::SIDE];
  logic [cbr_pkg::SIDE-1:0] xor_q [cbr_pkg::SIDE];
  logic [cbr_pkg::SIDE-1:0] and_set [cbr_pkg::SIDE];
  logic [cbr_pkg::SIDE-1:0] xor_set [cbr_pkg::SIDE];

  always_comb begin
    for (int r = 0; r < cbr_pkg::SIDE; r++) begin
      and_set[r] = '0;
      xor_set[r] = '0;
      for (int l = 0; l < cbr_pkg::LANES; l++) begin
        if (pix_i[l].ny == cbr_pkg::COORD_W'(r)) begin
          and_set[r][~pix_i[l].nx] = and_set[r][~pix_i[l].nx] | pix_i[l].and_b;
          xor_set[r][~pix_i[l].nx] = xor_set[r][~pix_i[l].nx] | pix_i[l].xor_b;
        end
      end
    end
  end

  // leftmost pixel (nx = 0) lands in the top bit
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      for (int r = 0; r < cbr_pkg::SIDE; r++) begin
        and_q[r] <= (clr_i ? '0 : and_q[r]) | and_set[r];
        xor_q[r] <= (clr_i ? '0 : xor_q[r]) | xor_set[r];
      end
    end
  end

  assign rd_and_o = and_q[rd_row_i];
  assign rd_xor_o = xor_q[rd_row_i];

endmodule

FILE: design/cursor_bitmap_rotator.sv
// Top level of the cursor bitmap rotator: pair counter, row emitter, stream ports.
// Takes a 32x32 monochrome cursor as 128 image/mask byte pairs, one transfer per
// cycle while collecting; eight pixel lanes place each pair into the rotated
// AND/XOR bit stores in the cycle it is accepted. The 128th pair, or any transfer
// with no_image set, starts a run of 32 row transfers (row 0 first, tlast on row
// 31), one per cycle while the sink is ready; the input side is held off until
// the last row has been loaded into the output register.
// Rotation is sampled on each accepted pair.
module cursor_bitmap_rotator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] image_byte, [15:8] mask_byte
  input  logic [cbr_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [0] no_image
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [4:0] row_index, [36:5] and_row, [68:37] xor_row, rest zero
  output logic [cbr_pkg::OUT_W-1:0]     m_axis_tdata,
  // last_row
  output logic                          m_axis_tlast
);

  cbr_pkg::rot_e                 rot_q;
  cbr_pkg::state_e               state_q, state_d;
  logic [cbr_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [cbr_pkg::COORD_W-1:0]   row_q, row_d;
  logic                          blank_q, blank_d;
  logic                          out_valid_q, out_valid_d;
  logic [cbr_pkg::COORD_W-1:0]   out_row_q;
  logic [cbr_pkg::SIDE-1:0]      out_and_q, out_xor_q;
  logic                          out_last_q;

  logic                          in_xfer;
  logic                          load;
  logic                          last_pair;
  logic [7:0]                    img, msk;
  logic [cbr_pkg::SIDE-1:0]      rd_and, rd_xor;
  cbr_pkg::pix_t [cbr_pkg::LANES-1:0] pix;

  assign img       = s_axis_tdata[7:0];
  assign msk       = s_axis_tdata[15:8];
  assign in_xfer   = s_axis_tvalid & s_axis_tready;
  assign last_pair = (cnt_q == cbr_pkg::CNT_W'(cbr_pkg::PAIRS - 1));

  for (genvar l = 0; l < cbr_pkg::LANES; l++) begin : g_lane
    cbr_lane u_lane (
      .x_i   ({cnt_q[cbr_pkg::BPR_W-1:0], cbr_pkg::LANE_W'(l)}),
      .y_i   (cnt_q[cbr_pkg::CNT_W-1:cbr_pkg::BPR_W]),
      .rot_i (rot_q),
      .img_i (img[cbr_pkg::LANES-1-l]),
      .msk_i (msk[cbr_pkg::LANES-1-l]),
      .pix_o (pix[l])
    );
  end

  cbr_store u_store (
    .clk_i    (clk_i),
    .wr_en_i  (in_xfer & ~s_axis_tuser),
    .clr_i    (cnt_q == '0),
    .pix_i    (pix),
    .rd_row_i (row_q),
    .rd_and_o (rd_and),
    .rd_xor_o (rd_xor)
  );

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    row_d   = row_q;
    blank_d = blank_q;
    case (state_q)
      cbr_pkg::ST_COLLECT: begin
        if (in_xfer) begin
          if (s_axis_tuser) begin
            cnt_d   = '0;
            blank_d = 1'b1;
            row_d   = '0;
            state_d = cbr_pkg::ST_EMIT;
          end else if (last_pair) begin
            cnt_d   = '0;
            blank_d = 1'b0;
            row_d   = '0;
            state_d = cbr_pkg::ST_EMIT;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      cbr_pkg::ST_EMIT: begin
        if (load) begin
          row_d = row_q + 1'b1;
          if (row_q == cbr_pkg::COORD_W'(cbr_pkg::SIDE - 1)) begin
            state_d = cbr_pkg::ST_COLLECT;
          end
        end
      end
      default: state_d = cbr_pkg::ST_COLLECT;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    load          = 1'b0;
    case (state_q)
      cbr_pkg::ST_COLLECT: s_axis_tready = 1'b1;
      cbr_pkg::ST_EMIT:    load = ~out_valid_q | m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
        load          = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbr_pkg::ST_COLLECT;
      rot_q       <= cbr_pkg::ROT_0;
      cnt_q       <= '0;
      row_q       <= '0;
      blank_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      blank_q     <= blank_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        rot_q <= cbr_pkg::rot_e'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_row_q  <= row_q;
      out_and_q  <= blank_q ? '1 : rd_and;
      out_xor_q  <= blank_q ? '0 : rd_xor;
      out_last_q <= (row_q == cbr_pkg::COORD_W'(cbr_pkg::SIDE - 1));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {(cbr_pkg::OUT_W - cbr_pkg::OUT_RAW_W)'(0),
                          out_xor_q, out_and_q, out_row_q};

endmodule

FILE: tb/cursor_row_checker.sv
`timescale 1ns / 100ps
// Checker for the cursor bitmap rotator: tracks rotation, predicts rows, compares them.
module cursor_row_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [cbr_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [cbr_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                          m_axis_tlast,
  output int                            fail_count_o,
  output int                            pending_o
);
  import cbr_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] row_index;
    logic [SIDE-1:0]    and_row;
    logic [SIDE-1:0]    xor_row;
    logic               last_row;
  } cursor_row_t;

  logic [SIDE-1:0] and_plane [SIDE];
  logic [SIDE-1:0] xor_plane [SIDE];
  int unsigned     pair_count;
  rot_e            rotation;
  cursor_row_t     rows_due [$];

  function automatic void clear_planes();
    for (int r = 0; r < SIDE; r++) begin
      and_plane[r] = '0;
      xor_plane[r] = '0;
    end
  endfunction

  // Drop the eight pixels of one image/mask pair into the rotated planes.
  function automatic void place_pair(logic [7:0] img, logic [7:0] msk);
    int unsigned y, x, nx, ny;
    y = pair_count / BPR;
    for (int i = 0; i < LANES; i++) begin
      x = (pair_count % BPR) * LANES + i;
      case (rotation)
        ROT_90: begin
          nx = SIDE - 1 - y;
          ny = x;
        end
        ROT_180: begin
          nx = SIDE - 1 - x;
          ny = SIDE - 1 - y;
        end
        ROT_270: begin
          nx = y;
          ny = SIDE - 1 - x;
        end
        default: begin
          nx = x;
          ny = y;
        end
      endcase
      and_plane[ny][SIDE-1-nx] = and_plane[ny][SIDE-1-nx] | ~msk[LANES-1-i];
      xor_plane[ny][SIDE-1-nx] = xor_plane[ny][SIDE-1-nx] | (img[LANES-1-i] & msk[LANES-1-i]);
    end
  endfunction

  function automatic void queue_rows(bit blank);
    cursor_row_t r;
    for (int i = 0; i < SIDE; i++) begin
      r.row_index = COORD_W'(i);
      r.and_row   = blank ? '1 : and_plane[i];
      r.xor_row   = blank ? '0 : xor_plane[i];
      r.last_row  = (i == SIDE - 1);
      rows_due.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [SIDE-1:0] want,
                                      logic [SIDE-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cursor_row_t got, want;
    if (!rst_ni) begin
      clear_planes();
      pair_count = 0;
      rotation   = ROT_0;
      rows_due.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) begin
          pair_count = 0;
          queue_rows(1'b1);
        end else begin
          if (pair_count == 0) clear_planes();
          place_pair(s_axis_tdata[7:0], s_axis_tdata[15:8]);
          pair_count++;
          if (pair_count == PAIRS) begin
            pair_count = 0;
            queue_rows(1'b0);
          end
        end
      end
      if (cfg_we_i) rotation = rot_e'(cfg_wdata_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.row_index = m_axis_tdata[COORD_W-1:0];
        got.and_row   = m_axis_tdata[COORD_W +: SIDE];
        got.xor_row   = m_axis_tdata[COORD_W+SIDE +: SIDE];
        got.last_row  = m_axis_tlast;
        if (rows_due.size() == 0) begin
          $error("row transfer with no row due: row_index %0d", got.row_index);
          fail_count_o++;
        end else begin
          want = rows_due.pop_front();
          check_field("row_index", SIDE'(want.row_index), SIDE'(got.row_index));
          check_field("and_row", want.and_row, got.and_row);
          check_field("xor_row", want.xor_row, got.xor_row);
          check_field("last_row", SIDE'(want.last_row), SIDE'(got.last_row));
        end
      end
    end
    pending_o = rows_due.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench top for the cursor bitmap rotator: clock, reset, stimulus and verdict.
module testbench;
  import cbr_pkg::*;

  localparam int HOLD_CYCLES  = 500;
  localparam int RANDOM_ITEMS = 360;
  localparam int MIN_IMAGES   = 3;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [1:0]           cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 idle_on       = 1'b1;
  logic                 hold_req      = 1'b0;
  int                   fail_count;
  int                   pending_rows;
  int unsigned          items_sent;

  cursor_bitmap_rotator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  cursor_row_checker row_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending_rows)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Row sink: random backpressure, plus one long hold-off once requested.
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(99) < 32);
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(logic [7:0] img, logic [7:0] msk, logic blank);
    while (idle_on && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {msk, img};
    s_axis_tuser  <= blank;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic drain_rows();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_rows != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_rotation(rot_e r);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned seq, full_images, len, kind;
    rot_e        rot_order [4];
    rot_order = '{ROT_270, ROT_90, ROT_180, ROT_0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // blank cursor straight out of reset, then with byte fields set
    send_item(8'h00, 8'h00, 1'b1);
    send_item(8'hFF, 8'hFF, 1'b1);
    // partial image discarded by a blank cursor
    send_item(8'h00, 8'h00, 1'b0);
    send_item(8'hFF, 8'h00, 1'b0);
    send_item(8'h00, 8'hFF, 1'b0);
    send_item(8'hFF, 8'hFF, 1'b0);
    send_item(8'hA5, 8'h5A, 1'b0);
    send_item(8'h5A, 8'hA5, 1'b0);
    send_item(8'h3C, 8'hC3, 1'b1);
    send_item(8'hFF, 8'hFF, 1'b0);
    send_item(8'h00, 8'h00, 1'b1);
    drain_rows();

    hold_req    <= 1'b1;
    seq         = 0;
    full_images = 0;
    while (items_sent < RANDOM_ITEMS || full_images < MIN_IMAGES) begin
      drain_rows();
      write_rotation(full_images < MIN_IMAGES ? rot_order[full_images]
                                              : rot_e'($urandom_range(3)));
      idle_on <= (seq != 2);
      kind = (full_images < MIN_IMAGES) ? 0 : $urandom_range(99);
      if (kind < 70) begin
        for (int i = 0; i < PAIRS; i++) send_item(pick_byte(), pick_byte(), 1'b0);
        // blank offered while the row sink is still held off
        if (seq == 0) send_item(8'($urandom), 8'($urandom), 1'b1);
        full_images++;
      end else if (kind < 90) begin
        len = $urandom_range(1, PAIRS - 1);
        for (int i = 0; i < len; i++) send_item(pick_byte(), pick_byte(), 1'b0);
        send_item(8'($urandom), 8'($urandom), 1'b1);
      end else begin
        send_item(8'($urandom), 8'($urandom), 1'b1);
      end
      seq++;
    end
    drain_rows();
    repeat (40) @(posedge clk_i);

    if (fail_count == 0 && pending_rows == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
